// ===== hw/rtl/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg
// Types, constants and decode helpers shared by the nibble processor blocks.
// ----------------------------------------------------------------------------
package npc_pkg;

    localparam int NPC_MEM_DEPTH = 256;
    localparam int NPC_NIB_W     = 4;
    localparam int NPC_ADDR_W    = 8;
    localparam int NPC_LIMIT_W   = 24;

    localparam logic [NPC_LIMIT_W-1:0] NPC_LIMIT_RESET = 24'd1000000;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_RUN   = 2'd2
    } t_mode;

    typedef enum logic [NPC_NIB_W-1:0] {
        OP_LOAD  = 4'd0,
        OP_STORE = 4'd1,
        OP_SWAP  = 4'd2,
        OP_ADD   = 4'd3,
        OP_INC   = 4'd4,
        OP_DEC   = 4'd5,
        OP_JZ    = 4'd6,
        OP_JUMP  = 4'd7,
        OP_HALT  = 4'd8
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_FETCH,
        ST_DECODE,
        ST_OPER_HI,
        ST_OPER_LO,
        ST_LOAD_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        ADR_REQ,
        ADR_PC,
        ADR_PC1,
        ADR_PC2,
        ADR_TGT
    } t_addr_sel;

    typedef struct packed {
        logic [1:0]            mode;
        logic [NPC_ADDR_W-1:0] address;
        logic [NPC_NIB_W-1:0]  write_nibble;
    } t_req;

    typedef struct packed {
        logic [NPC_NIB_W-1:0] read_nibble;
        logic                 run_halted;
        logic                 run_timed_out;
    } t_rsp;

    typedef struct packed {
        logic [NPC_LIMIT_W-1:0] step_limit;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        t_addr_sel ram_sel;
        logic      ram_we;
        logic      wdata_from_a;
        logic      clr_result;
        logic      run_clear;
        logic      step_inc;
        logic      latch_op;
        logic      latch_hi;
        logic      exec_short;
        logic      exec_long;
        logic      load_a;
        logic      cap_read;
        logic      set_halt;
        logic      set_timeout;
        logic      push;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [NPC_NIB_W-1:0] rdata;
        logic [NPC_NIB_W-1:0] op;
        logic                 limit_hit;
        logic                 out_free;
    } t_stat;

    function automatic logic has_operand(input logic [NPC_NIB_W-1:0] op);
        return (op == OP_LOAD) || (op == OP_STORE) || (op == OP_JZ) || (op == OP_JUMP);
    endfunction

endpackage

// ===== hw/rtl/npc_chan_if.sv =====
// ----------------------------------------------------------------------------
// npc_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface npc_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/npc_ram.sv =====
// ----------------------------------------------------------------------------
// npc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/npc_dp.sv =====
// ----------------------------------------------------------------------------
// npc_dp
// Datapath: program memory, PC, A/B registers, step counter, step limit,
// result fields and the output register.
// ----------------------------------------------------------------------------
module npc_dp import npc_pkg::*; #(
    parameter int MEM_DEPTH = NPC_MEM_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_req  i_req,
    input  logic  i_cfg_we,
    input  t_cfg  i_cfg,
    input  logic  i_rsp_ready,
    output t_stat o_stat,
    output logic  o_rsp_valid,
    output t_rsp  o_rsp
);

    localparam int AW = $clog2(MEM_DEPTH);

    logic [AW-1:0]          r_pc;
    logic [NPC_NIB_W-1:0]   r_a;
    logic [NPC_NIB_W-1:0]   r_b;
    logic [NPC_LIMIT_W-1:0] r_step_count;
    logic [NPC_LIMIT_W-1:0] r_step_limit;
    logic [NPC_NIB_W-1:0]   r_op;
    logic [NPC_NIB_W-1:0]   r_hi;
    logic [NPC_NIB_W-1:0]   r_rd_nib;
    logic                   r_halted;
    logic                   r_timed;
    logic                   r_out_valid;
    t_rsp                   r_out;

    logic [AW-1:0]          ram_addr;
    logic [NPC_NIB_W-1:0]   ram_wdata;
    logic [NPC_NIB_W-1:0]   ram_rdata;
    logic [AW-1:0]          target;
    logic [NPC_NIB_W:0]     sum;

    assign target = AW'({r_hi, ram_rdata});
    assign sum    = {1'b0, r_a} + {1'b0, r_b};

    always_comb begin
        unique case (i_cmd.ram_sel)
            ADR_REQ: ram_addr = AW'(i_req.address);
            ADR_PC:  ram_addr = r_pc;
            ADR_PC1: ram_addr = r_pc + AW'(1);
            ADR_PC2: ram_addr = r_pc + AW'(2);
            ADR_TGT: ram_addr = target;
            default: ram_addr = r_pc;
        endcase
    end

    assign ram_wdata = i_cmd.wdata_from_a ? r_a : i_req.write_nibble;

    npc_ram #(
        .WIDTH (NPC_NIB_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // processor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= '0;
            r_a          <= '0;
            r_b          <= '0;
            r_step_count <= '0;
        end else if (i_cmd.run_clear) begin
            r_pc         <= '0;
            r_a          <= '0;
            r_b          <= '0;
            r_step_count <= '0;
        end else begin
            if (i_cmd.step_inc) begin
                r_step_count <= r_step_count + NPC_LIMIT_W'(1);
            end
            if (i_cmd.exec_short) begin
                r_pc <= r_pc + AW'(1);
                case (t_opcode'(ram_rdata))
                    OP_SWAP: begin
                        r_a <= r_b;
                        r_b <= r_a;
                    end
                    OP_ADD: begin
                        r_a <= sum[NPC_NIB_W-1:0];
                        r_b <= NPC_NIB_W'(sum[NPC_NIB_W]);
                    end
                    OP_INC:  r_a <= r_a + NPC_NIB_W'(1);
                    OP_DEC:  r_a <= r_a - NPC_NIB_W'(1);
                    default: ;
                endcase
            end
            if (i_cmd.exec_long) begin
                if ((r_op == OP_JUMP) || ((r_op == OP_JZ) && (r_a == '0))) begin
                    r_pc <= target;
                end else begin
                    r_pc <= r_pc + AW'(3);
                end
            end
            if (i_cmd.load_a) begin
                r_a <= ram_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= NPC_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_step_limit <= i_cfg.step_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_op) begin
            r_op <= ram_rdata;
        end
        if (i_cmd.latch_hi) begin
            r_hi <= ram_rdata;
        end
    end

    // result fields of the item in progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_nib <= '0;
            r_halted <= 1'b0;
            r_timed  <= 1'b0;
        end else if (i_cmd.clr_result) begin
            r_rd_nib <= '0;
            r_halted <= 1'b0;
            r_timed  <= 1'b0;
        end else begin
            if (i_cmd.cap_read) begin
                r_rd_nib <= ram_rdata;
            end
            if (i_cmd.set_halt) begin
                r_halted <= 1'b1;
            end
            if (i_cmd.set_timeout) begin
                r_timed <= 1'b1;
            end
        end
    end

    // output register: a new push replaces an entry taken in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out.read_nibble   <= r_rd_nib;
            r_out.run_halted    <= r_halted;
            r_out.run_timed_out <= r_timed;
        end
    end

    assign o_rsp_valid      = r_out_valid;
    assign o_rsp            = r_out;
    assign o_stat.rdata     = ram_rdata;
    assign o_stat.op        = r_op;
    assign o_stat.limit_hit = (r_step_count >= r_step_limit);
    assign o_stat.out_free  = !r_out_valid || i_rsp_ready;

endmodule

// ===== hw/rtl/npc_ctrl.sv =====
// ----------------------------------------------------------------------------
// npc_ctrl
// Controller: sequences request handling and instruction fetch/execute.
// ----------------------------------------------------------------------------
module npc_ctrl import npc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_req_valid,
    input  t_req   i_req,
    input  t_stat  i_stat,
    output logic   o_req_ready,
    output t_cmd   o_cmd,
    output t_state o_state
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.ram_sel = ADR_PC;
        o_req_ready   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_req_ready     = 1'b1;
                o_cmd.ram_sel   = ADR_REQ;
                if (i_req_valid) begin
                    o_cmd.clr_result = 1'b1;
                    case (t_mode'(i_req.mode))
                        MODE_WRITE: begin
                            o_cmd.ram_we = 1'b1;
                            n_state      = ST_DONE;
                        end
                        MODE_READ: n_state = ST_RD_WAIT;
                        MODE_RUN: begin
                            o_cmd.run_clear = 1'b1;
                            n_state         = ST_FETCH;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_RD_WAIT: begin
                o_cmd.cap_read = 1'b1;
                n_state        = ST_DONE;
            end
            ST_FETCH: begin
                if (i_stat.limit_hit) begin
                    o_cmd.set_timeout = 1'b1;
                    n_state           = ST_DONE;
                end else begin
                    o_cmd.ram_sel  = ADR_PC;
                    o_cmd.step_inc = 1'b1;
                    n_state        = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (has_operand(i_stat.rdata)) begin
                    o_cmd.latch_op = 1'b1;
                    o_cmd.ram_sel  = ADR_PC1;
                    n_state        = ST_OPER_HI;
                end else if (i_stat.rdata == OP_HALT) begin
                    o_cmd.set_halt = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.exec_short = 1'b1;
                    n_state          = ST_FETCH;
                end
            end
            ST_OPER_HI: begin
                o_cmd.latch_hi = 1'b1;
                o_cmd.ram_sel  = ADR_PC2;
                n_state        = ST_OPER_LO;
            end
            ST_OPER_LO: begin
                o_cmd.exec_long = 1'b1;
                o_cmd.ram_sel   = ADR_TGT;
                n_state         = ST_FETCH;
                if (i_stat.op == OP_LOAD) begin
                    n_state = ST_LOAD_WAIT;
                end else if (i_stat.op == OP_STORE) begin
                    o_cmd.ram_we       = 1'b1;
                    o_cmd.wdata_from_a = 1'b1;
                end
            end
            ST_LOAD_WAIT: begin
                o_cmd.load_a = 1'b1;
                n_state      = ST_FETCH;
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_state = r_state;

endmodule

// ===== hw/rtl/nibble_processor_core.sv =====
// ----------------------------------------------------------------------------
// nibble_processor_core
// 4-bit processor with 256 nibbles of shared program/data memory. Requests
// write a nibble, read a nibble, or run the stored program from address 0.
//
//   channel  dir  payload                                       protocol
//   i_req    in   mode, address, write_nibble                   valid/ready
//   o_rsp    out  read_nibble, run_halted, run_timed_out        valid/ready
//   i_cfg    in   step_limit                                    valid/ready
//
// One request at a time. A read goes through the registered RAM read.
// A run fetches and decodes each opcode; store, load and jumps then read two
// operand nibbles, load reads its data nibble in a further wait state, and
// a run that times out ends with a final limit check in the fetch state.
// Reset clears registers only; memory content is undefined until written.
// A result waits in the output register; the next request is still taken,
// and the block stalls only when finishing with the previous result unclaimed.
// ----------------------------------------------------------------------------
module nibble_processor_core import npc_pkg::*; #(
    parameter int MEM_DEPTH = NPC_MEM_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    npc_chan_if.sink        i_req,
    npc_chan_if.source      o_rsp,
    npc_chan_if.sink        i_cfg
);

    t_cmd   cmd;
    t_stat  stat;
    t_state state;
    t_req   req;
    t_cfg   cfg;
    t_rsp   rsp;
    logic   req_ready;
    logic   rsp_valid;

    assign req = i_req.data;
    assign cfg = i_cfg.data;

    npc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req       (req),
        .i_stat      (stat),
        .o_req_ready (req_ready),
        .o_cmd       (cmd),
        .o_state     (state)
    );

    npc_dp #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (req),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg       (cfg),
        .i_rsp_ready (o_rsp.ready),
        .o_stat      (stat),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp)
    );

    assign i_req.ready = req_ready;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = rsp_valid;
    assign o_rsp.data  = rsp;

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !(rsp.run_halted && rsp.run_timed_out))
        else $error("run reported both halted and timed out");

    a_run_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && (rsp.run_halted || rsp.run_timed_out) |-> rsp.read_nibble == '0)
        else $error("run result carries a read nibble");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in progress");

    a_step_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step_inc |-> !stat.limit_hit && state == ST_FETCH)
        else $error("instruction started past the step limit");

endmodule
